### src/gic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_pkg
// Shared types, codes and constants of the gamepad input conditioner.
// ----------------------------------------------------------------------------
package gic_pkg;

  localparam logic [2:0] ACT_FRAME_START = 3'd0;
  localparam logic [2:0] ACT_BTN_DOWN    = 3'd1;
  localparam logic [2:0] ACT_BTN_UP      = 3'd2;
  localparam logic [2:0] ACT_AXIS        = 3'd3;
  localparam logic [2:0] ACT_FRAME_END   = 3'd4;

  localparam logic [2:0] AXIS_LX = 3'd0;
  localparam logic [2:0] AXIS_LY = 3'd1;
  localparam logic [2:0] AXIS_RX = 3'd2;
  localparam logic [2:0] AXIS_RY = 3'd3;
  localparam logic [2:0] AXIS_LT = 3'd4;
  localparam logic [2:0] AXIS_RT = 3'd5;

  localparam logic [1:0] BS_NOT_PRESSED = 2'd0;
  localparam logic [1:0] BS_DOWN        = 2'd1;
  localparam logic [1:0] BS_HELD        = 2'd2;
  localparam logic [1:0] BS_UP          = 2'd3;

  localparam logic CFG_STICK_DZ = 1'b0;
  localparam logic CFG_TRIG_DZ  = 1'b1;

  localparam logic [14:0] UNIT_MAX    = 15'd32766;
  localparam logic [29:0] UNIT_MAX_SQ = 30'd1073610756;
  localparam int          DIV_STEPS   = 30;
  localparam int          SQRT_STEPS  = 15;
  localparam int          REPORTED_BUTTONS = 15;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DZ, ST_SQX, ST_SQY, ST_LEN, ST_PROD, ST_DINIT, ST_DIV,
    ST_SINIT, ST_SQRT, ST_WRB, ST_TRIG, ST_EMIT
  } gic_state_e;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_DZ, MUL_SQX, MUL_SQY, MUL_PROD
  } mul_sel_e;

  typedef struct packed {
    logic     load_event;
    mul_sel_e mul_sel;
    logic     stick_sel;
    logic     comp_sel;
    logic     len_load;
    logic     stick_zero;
    logic     div_init;
    logic     div_step;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     comp_write;
    logic     trig_cond;
    logic     out_load;
  } gic_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic below_dz;
    logic over_max;
    logic div_last;
    logic sqrt_last;
  } gic_status_t;

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    abs17 = v[16] ? 17'(-v) : 17'(v);
  endfunction

  function automatic logic signed [15:0] cond_trig(input logic signed [15:0] t,
                                                   input logic [14:0] dz);
    logic signed [16:0] te;
    logic signed [16:0] dzs;
    te  = {t[15], t};
    dzs = {2'b00, dz};
    if (te < dzs) begin
      cond_trig = '0;
    end else if (te > $signed({2'b00, UNIT_MAX})) begin
      cond_trig = $signed({1'b0, UNIT_MAX});
    end else begin
      cond_trig = t;
    end
  endfunction

endpackage

### src/gic_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_ctrl
// Sequencer for event handling and the frame end conditioning steps.
// ----------------------------------------------------------------------------
module gic_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  gic_pkg::gic_status_t status_i,
  output gic_pkg::gic_cmd_t    cmd_o
);
  import gic_pkg::*;

  gic_state_e state_q, state_d;
  logic       stick_q, stick_d;
  logic       comp_q, comp_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stick_q     <= 1'b0;
      comp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stick_q     <= stick_d;
      comp_q      <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    stick_d        = stick_q;
    comp_d         = comp_q;
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_NONE;
    cmd_o.stick_sel = stick_q;
    cmd_o.comp_sel = comp_q;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_event = 1'b1;
          state_d = status_i.frame_end ? ST_DZ : ST_EMIT;
        end
      end
      ST_DZ: begin
        cmd_o.mul_sel = MUL_DZ;
        stick_d = 1'b0;
        state_d = ST_SQX;
      end
      ST_SQX: begin
        cmd_o.mul_sel = MUL_SQX;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.mul_sel = MUL_SQY;
        state_d = ST_LEN;
      end
      ST_LEN: begin
        if (status_i.below_dz) begin
          cmd_o.stick_zero = 1'b1;
        end else if (status_i.over_max) begin
          cmd_o.len_load = 1'b1;
          comp_d = 1'b0;
        end
        if (!status_i.below_dz && status_i.over_max) begin
          state_d = ST_PROD;
        end else if (!stick_q) begin
          stick_d = 1'b1;
          state_d = ST_SQX;
        end else begin
          state_d = ST_TRIG;
        end
      end
      ST_PROD: begin
        cmd_o.mul_sel = MUL_PROD;
        state_d = ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_SINIT;
      end
      ST_SINIT: begin
        cmd_o.sqrt_init = 1'b1;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_last) state_d = ST_WRB;
      end
      ST_WRB: begin
        cmd_o.comp_write = 1'b1;
        if (!comp_q) begin
          comp_d  = 1'b1;
          state_d = ST_PROD;
        end else if (!stick_q) begin
          stick_d = 1'b1;
          state_d = ST_SQX;
        end else begin
          state_d = ST_TRIG;
        end
      end
      ST_TRIG: begin
        cmd_o.trig_cond = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/gic_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_dp
// Button and axis state, shared multiplier, divider and square root unit.
// ----------------------------------------------------------------------------
module gic_dp #(
  parameter int NUM_BUTTONS = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gic_pkg::gic_cmd_t    cmd_i,
  output gic_pkg::gic_status_t status_o,
  input  logic [2:0]           action_i,
  input  logic [7:0]           button_code_i,
  input  logic [2:0]           axis_code_i,
  input  logic signed [15:0]   axis_value_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_index_i,
  input  logic [14:0]          cfg_data_i,
  output logic [29:0]          button_states_o,
  output logic signed [16:0]   left_x_o,
  output logic signed [16:0]   left_y_o,
  output logic signed [16:0]   right_x_o,
  output logic signed [16:0]   right_y_o,
  output logic signed [15:0]   left_trigger_o,
  output logic signed [15:0]   right_trigger_o
);
  import gic_pkg::*;

  logic [2*NUM_BUTTONS-1:0] btn_q;
  logic signed [16:0] lx_q, ly_q, rx_q, ry_q;
  logic signed [15:0] lt_q, rt_q;
  logic [14:0] sdz_q, tdz_q;
  logic [29:0] dz2_q;
  logic [31:0] sqx_q, sqy_q, len_q;
  logic [59:0] prod_q;
  logic [31:0] rem_q;
  logic [29:0] sh_q;
  logic [14:0] root_q;
  logic [16:0] srem_q;
  logic [4:0]  cnt_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] len2, csq;
  logic signed [16:0] cur_x, cur_y, cur_c, new_c;
  logic [32:0] rem_s;
  logic        div_ge;
  logic [18:0] srem_s, trial;
  logic        sq_ge;
  logic [29:0] btn_pack;

  assign cur_x = cmd_i.stick_sel ? rx_q : lx_q;
  assign cur_y = cmd_i.stick_sel ? ry_q : ly_q;
  assign cur_c = cmd_i.comp_sel ? cur_y : cur_x;
  assign csq   = cmd_i.comp_sel ? sqy_q : sqx_q;
  assign len2  = sqx_q + sqy_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_DZ: begin
        mul_a = {17'd0, sdz_q};
        mul_b = {17'd0, sdz_q};
      end
      MUL_SQX: begin
        mul_a = {15'd0, abs17(cur_x)};
        mul_b = {15'd0, abs17(cur_x)};
      end
      MUL_SQY: begin
        mul_a = {15'd0, abs17(cur_y)};
        mul_b = {15'd0, abs17(cur_y)};
      end
      MUL_PROD: begin
        mul_a = csq;
        mul_b = {2'b00, UNIT_MAX_SQ};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // restoring divide: one quotient bit per step into the shift register
  assign rem_s  = {rem_q, sh_q[29]};
  assign div_ge = rem_s >= {1'b0, len_q};
  // digit by digit root, radicand shifts out of the same register
  assign srem_s = {srem_q, sh_q[29:28]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sq_ge  = srem_s >= trial;
  assign new_c  = cur_c[16] ? -$signed({2'b00, root_q}) : $signed({2'b00, root_q});

  assign status_o.frame_end = (action_i == ACT_FRAME_END);
  assign status_o.below_dz  = len2 < {2'b00, dz2_q};
  assign status_o.over_max  = len2 > {2'b00, UNIT_MAX_SQ};
  assign status_o.div_last  = (cnt_q == 5'(DIV_STEPS - 1));
  assign status_o.sqrt_last = (cnt_q == 5'(SQRT_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q <= '0;
      lx_q  <= '0;
      ly_q  <= '0;
      rx_q  <= '0;
      ry_q  <= '0;
      lt_q  <= '0;
      rt_q  <= '0;
      sdz_q <= '0;
      tdz_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_STICK_DZ) sdz_q <= cfg_data_i;
        if (cfg_index_i == CFG_TRIG_DZ)  tdz_q <= cfg_data_i;
      end
      if (cmd_i.load_event) begin
        case (action_i)
          ACT_FRAME_START: begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
              if (btn_q[2*i +: 2] == BS_DOWN) btn_q[2*i +: 2] <= BS_HELD;
              else if (btn_q[2*i +: 2] == BS_UP) btn_q[2*i +: 2] <= BS_NOT_PRESSED;
            end
          end
          ACT_BTN_DOWN: begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
              if (button_code_i == 8'(i)) btn_q[2*i +: 2] <= BS_DOWN;
            end
          end
          ACT_BTN_UP: begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
              if (button_code_i == 8'(i)) btn_q[2*i +: 2] <= BS_UP;
            end
          end
          ACT_AXIS: begin
            case (axis_code_i)
              AXIS_LX: lx_q <= {axis_value_i[15], axis_value_i};
              AXIS_LY: ly_q <= -$signed({axis_value_i[15], axis_value_i});
              AXIS_RX: rx_q <= {axis_value_i[15], axis_value_i};
              AXIS_RY: ry_q <= -$signed({axis_value_i[15], axis_value_i});
              AXIS_LT: lt_q <= axis_value_i;
              AXIS_RT: rt_q <= axis_value_i;
              default: ;
            endcase
          end
          default: ;
        endcase
      end else if (cmd_i.stick_zero) begin
        if (cmd_i.stick_sel) begin
          rx_q <= '0;
          ry_q <= '0;
        end else begin
          lx_q <= '0;
          ly_q <= '0;
        end
      end else if (cmd_i.comp_write) begin
        case ({cmd_i.stick_sel, cmd_i.comp_sel})
          2'b00:   lx_q <= new_c;
          2'b01:   ly_q <= new_c;
          2'b10:   rx_q <= new_c;
          default: ry_q <= new_c;
        endcase
      end else if (cmd_i.trig_cond) begin
        lt_q <= cond_trig(lt_q, tdz_q);
        rt_q <= cond_trig(rt_q, tdz_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.mul_sel)
      MUL_DZ:   dz2_q  <= mul_p[29:0];
      MUL_SQX:  sqx_q  <= mul_p[31:0];
      MUL_SQY:  sqy_q  <= mul_p[31:0];
      MUL_PROD: prod_q <= mul_p[59:0];
      default: ;
    endcase
    if (cmd_i.len_load) len_q <= len2;
    if (cmd_i.div_init) begin
      rem_q <= {2'b00, prod_q[59:30]};
      sh_q  <= prod_q[29:0];
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? 32'(rem_s - {1'b0, len_q}) : 32'(rem_s);
      sh_q  <= {sh_q[28:0], div_ge};
      cnt_q <= cnt_q + 5'd1;
    end else if (cmd_i.sqrt_init) begin
      root_q <= '0;
      srem_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.sqrt_step) begin
      srem_q <= sq_ge ? 17'(srem_s - trial) : 17'(srem_s);
      root_q <= {root_q[13:0], sq_ge};
      sh_q   <= {sh_q[27:0], 2'b00};
      cnt_q  <= cnt_q + 5'd1;
    end
  end

  for (genvar g = 0; g < REPORTED_BUTTONS; g++) begin : g_pack
    if (g < NUM_BUTTONS) begin : g_on
      assign btn_pack[2*g +: 2] = btn_q[2*g +: 2];
    end else begin : g_off
      assign btn_pack[2*g +: 2] = BS_NOT_PRESSED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      button_states_o <= btn_pack;
      left_x_o        <= lx_q;
      left_y_o        <= ly_q;
      right_x_o       <= rx_q;
      right_y_o       <= ry_q;
      left_trigger_o  <= lt_q;
      right_trigger_o <= rt_q;
    end
  end

endmodule

### src/gamepad_input_conditioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_input_conditioner
// Button edge tracking and stick/trigger deadzone conditioning.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (in_valid_i/in_ready_o) carries one controller event per
//    transfer; every event yields exactly one result on the output channel
//    (out_valid_o/out_ready_i): the full button and axis state after it
//  - config channel writes stick_deadzone (index 0) or trigger_deadzone
//    (index 1); cfg_ready_o is always high, write only while idle
//  - one event at a time: for every event but frame end the sequencer goes
//    from the input transfer straight to the emit step, which registers the
//    result, and then takes the next event
//  - frame end runs the deadzone, squaring and length steps per stick, and
//    for every stick component that is rescaled one 30-step divide and one
//    15-step root on a shared unit, then the trigger step
//  - the output register lets the next event in while a result waits; a
//    stalled receiver holds the following result in the last sequencer step
//  - reset clears all buttons, axes and deadzones to zero
module gamepad_input_conditioner #(
  parameter int NUM_BUTTONS = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic [7:0]         button_code_i,
  input  logic [2:0]         axis_code_i,
  input  logic signed [15:0] axis_value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [29:0]        button_states_o,
  output logic signed [16:0] left_x_o,
  output logic signed [16:0] left_y_o,
  output logic signed [16:0] right_x_o,
  output logic signed [16:0] right_y_o,
  output logic signed [15:0] left_trigger_o,
  output logic signed [15:0] right_trigger_o
);
  import gic_pkg::*;

  gic_cmd_t    cmd;
  gic_status_t status;

  assign cfg_ready_o = 1'b1;

  gic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gic_dp #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .action_i        (action_i),
    .button_code_i   (button_code_i),
    .axis_code_i     (axis_code_i),
    .axis_value_i    (axis_value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .button_states_o (button_states_o),
    .left_x_o        (left_x_o),
    .left_y_o        (left_y_o),
    .right_x_o       (right_x_o),
    .right_y_o       (right_y_o),
    .left_trigger_o  (left_trigger_o),
    .right_trigger_o (right_trigger_o)
  );

  // only one event in flight
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("event accepted while another is in flight");

  // a new result is only produced by the sequencer, never from idle
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised without a pending event");

endmodule
